>>> sv/qpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared constants, types and helpers of the quoted-printable decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

  // Characters of interest
  localparam logic [7:0] QPD_EQ = 8'h3D;
  localparam logic [7:0] QPD_CR = 8'h0D;
  localparam logic [7:0] QPD_LF = 8'h0A;

  // Digit conversion offsets and range bound
  localparam logic [7:0] QPD_ALPHA_LO  = 8'h40;
  localparam logic [7:0] QPD_OFS_DIGIT = 8'h30;
  localparam logic [7:0] QPD_OFS_ALPHA = 8'h37;

  // Escape phase codes
  localparam logic [1:0] QPD_PH_PLAIN = 2'd0;
  localparam logic [1:0] QPD_PH_EQ    = 2'd1;
  localparam logic [1:0] QPD_PH_DIG1  = 2'd2;
  localparam logic [1:0] QPD_PH_SOFT  = 2'd3;

  // One decode step's outcome
  typedef struct packed {
    logic       emit;
    logic       has_byte;
    logic       part_done;
    logic [7:0] data;
  } qpd_res_t;

  // Convert an escape character to its nibble value (kept to 8 bits)
  function automatic logic [7:0] qpd_digit(input logic [7:0] c);
    logic [7:0] d;
    if ((c < QPD_ALPHA_LO) || c[7]) begin
      d = c - QPD_OFS_DIGIT;
    end else begin
      d = c - QPD_OFS_ALPHA;
    end
    return d;
  endfunction

  function automatic logic qpd_is_eol(input logic [7:0] c);
    return (c == QPD_CR) || (c == QPD_LF);
  endfunction

endpackage

>>> sv/quoted_printable_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_printable_decoder_unit
// Quoted-printable body decoder: one encoded byte in, at most one decoded
// byte out, with the final item of a body always answered by a closing item.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                          | Direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_ready, in_byte, in_end_of_body    | in
//   result  | out_valid, out_ready, out_byte, out_has_byte,  | out
//           | out_part_done                                  |
//
// One item per cycle unless a stalled result holds it up; an item passes the
// input register, then the result register, with the decode between them.
// Reset (rst_n low, synchronous) empties both registers and returns the
// escape state to plain text.
// A stalled result holds the result register; the input register keeps
// draining items that produce no result, and accepts a new item whenever it
// is empty or moving on in the same cycle.
module quoted_printable_decoder_unit
  import qpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_body,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_part_done
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_has_r;
  logic       out_done_r;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;
  qpd_res_t   res;

  qpd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .cur_byte (s1_byte_r),
    .cur_last (s1_last_r),
    .res      (res)
  );

  // Handshake flow between the two registers
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!res.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_end_of_body;
    end
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_byte_r <= res.data;
      out_has_r  <= res.has_byte;
      out_done_r <= res.part_done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_has_byte  = out_has_r;
  assign out_part_done = out_done_r;

endmodule

>>> sv/qpd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_decode
// Escape state and per-byte decode logic: updates the state on each step
// and reports whether a result item is produced.
// ----------------------------------------------------------------------------
module qpd_decode
  import qpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] cur_byte,
  input  logic       cur_last,
  output qpd_res_t   res
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic       have;
  logic [7:0] val;

  // Decode the current byte against the escape phase
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    have      = 1'b0;
    val       = 8'h00;
    case (phase_r)
      QPD_PH_EQ: begin
        if (qpd_is_eol(cur_byte)) begin
          phase_nxt = QPD_PH_SOFT;
        end else begin
          first_nxt = qpd_digit(cur_byte);
          phase_nxt = QPD_PH_DIG1;
        end
      end
      QPD_PH_DIG1: begin
        val       = {first_r[3:0], 4'h0} | qpd_digit(cur_byte);
        have      = 1'b1;
        phase_nxt = QPD_PH_PLAIN;
      end
      QPD_PH_SOFT: begin
        if (!qpd_is_eol(cur_byte)) begin
          if (cur_byte == QPD_EQ) begin
            phase_nxt = QPD_PH_EQ;
          end else begin
            val       = cur_byte;
            have      = 1'b1;
            phase_nxt = QPD_PH_PLAIN;
          end
        end
      end
      default: begin
        if (cur_byte == QPD_EQ) begin
          phase_nxt = QPD_PH_EQ;
        end else begin
          val       = cur_byte;
          have      = 1'b1;
          phase_nxt = QPD_PH_PLAIN;
        end
      end
    endcase
    // End of body closes any open escape
    if (cur_last) begin
      phase_nxt = QPD_PH_PLAIN;
      first_nxt = 8'h00;
    end
  end

  assign res.emit      = have | cur_last;
  assign res.has_byte  = have;
  assign res.part_done = cur_last;
  assign res.data      = have ? val : 8'h00;

  // Advance state on each consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= QPD_PH_PLAIN;
      first_r <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

>>> dv/tb_quoted_printable_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_printable_decoder_unit
// Self-checking bench for the quoted-printable decoder. A scoreboard class
// tracks the escape state of the stream, works out the decoded item due for
// each accepted encoded byte and compares it with what leaves the block.
// Five short directed bodies run first, then random bodies under several
// sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_quoted_printable_decoder_unit;
  import qpd_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          ITEMS_PER_LOAD = 200;
  localparam int          SETTLE_CYCLES  = 16;
  localparam logic [7:0]  TOP_HALF       = 8'h80;

  // One decoded item as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       part_done;
  } qp_result_t;

  // Tracks the escape state and holds the decoded items still due
  class qp_byte_scoreboard;
    logic [1:0]  phase;
    logic [7:0]  hi_nibble;
    qp_result_t  due_bytes[$];
    int          error_count;

    function new();
      phase       = QPD_PH_PLAIN;
      hi_nibble   = 8'h00;
      error_count = 0;
    endfunction

    function logic [7:0] nibble_of(input logic [7:0] c);
      if ((c < QPD_ALPHA_LO) || (c >= TOP_HALF)) begin
        return c - QPD_OFS_DIGIT;
      end
      return c - QPD_OFS_ALPHA;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
    endtask

    function int pending();
      return due_bytes.size();
    endfunction

    // Advance the escape state by one accepted byte and queue what it yields
    function void decode_byte(input logic [7:0] c, input logic eob);
      logic       got;
      logic       eol;
      logic [7:0] val;
      qp_result_t r;
      got = 1'b0;
      val = 8'h00;
      eol = (c == QPD_CR) || (c == QPD_LF);
      case (phase)
        QPD_PH_EQ: begin
          if (eol) begin
            phase = QPD_PH_SOFT;
          end else begin
            hi_nibble = nibble_of(c);
            phase     = QPD_PH_DIG1;
          end
        end
        QPD_PH_DIG1: begin
          val   = (hi_nibble << 4) | nibble_of(c);
          got   = 1'b1;
          phase = QPD_PH_PLAIN;
        end
        default: begin
          // A soft break swallows CR/LF; '=' opens an escape, anything else is plain text
          if (!((phase == QPD_PH_SOFT) && eol)) begin
            if (c == QPD_EQ) begin
              phase = QPD_PH_EQ;
            end else begin
              val   = c;
              got   = 1'b1;
              phase = QPD_PH_PLAIN;
            end
          end
        end
      endcase
      if (eob) begin
        r.data      = got ? val : 8'h00;
        r.has_byte  = got;
        r.part_done = 1'b1;
        due_bytes.push_back(r);
        phase     = QPD_PH_PLAIN;
        hi_nibble = 8'h00;
      end else if (got) begin
        r.data      = val;
        r.has_byte  = 1'b1;
        r.part_done = 1'b0;
        due_bytes.push_back(r);
      end
    endfunction

    // Compare one result against the oldest item due
    task check_result(input logic [7:0] data, input logic has_byte,
                      input logic part_done);
      qp_result_t want;
      if (due_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte=%h has=%b done=%b",
                                  data, has_byte, part_done));
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data) begin
        report_mismatch($sformatf("out_byte %h, want %h", data, want.data));
      end
      if (has_byte !== want.has_byte) begin
        report_mismatch($sformatf("out_has_byte %b, want %b", has_byte,
                                  want.has_byte));
      end
      if (part_done !== want.part_done) begin
        report_mismatch($sformatf("out_part_done %b, want %b", part_done,
                                  want.part_done));
      end
    endtask

    task flag_leftovers();
      while (due_bytes.size() != 0) begin
        qp_result_t left;
        left = due_bytes.pop_front();
        report_mismatch($sformatf("missing item byte=%h has=%b done=%b",
                                  left.data, left.has_byte, left.part_done));
      end
    endtask
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte        = 8'h00;
  logic       in_end_of_body = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_part_done;

  qp_byte_scoreboard sb = new();
  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int cycles     = 0;

  quoted_printable_decoder_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_end_of_body(in_end_of_body),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_has_byte  (out_has_byte),
    .out_part_done (out_part_done)
  );

  always #1 clk = ~clk;

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every item that leaves the block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_byte, out_has_byte, out_part_done);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("tb_quoted_printable_decoder_unit failed");
      $finish;
    end
  end

  // Offer one encoded byte, with random gaps ahead of it
  task automatic drive_item(input logic [7:0] b, input logic eob);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_body <= eob;
    do @(posedge clk); while (!in_ready);
    sb.decode_byte(b, eob);
    items_sent++;
  endtask

  // Hold the sender until every due item has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int n, input bit lower);
    if (n < 10) return 8'h30 + n[7:0];
    return (lower ? 8'h57 : 8'h37) + n[7:0];
  endfunction

  function automatic logic [7:0] eol_char();
    return $urandom_range(0, 1) ? QPD_CR : QPD_LF;
  endfunction

  // Build one random body from plain bytes, escapes and soft breaks, then send it
  task automatic run_body();
    logic [7:0] body[$];
    logic [7:0] b;
    int         n_tok;
    int         kind;
    int         k;
    n_tok = $urandom_range(1, 12);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        b = 8'($urandom_range(0, 255));
        if (b == QPD_EQ) b = ~b;
        body.push_back(b);
      end else if (kind < 72) begin
        body.push_back(QPD_EQ);
        body.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 3) == 0));
        body.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 3) == 0));
      end else if (kind < 82) begin
        // Escape with arbitrary characters
        b = 8'($urandom_range(0, 255));
        if ((b == QPD_CR) || (b == QPD_LF)) b = b | TOP_HALF;
        body.push_back(QPD_EQ);
        body.push_back(b);
        body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        body.push_back(QPD_EQ);
        k = $urandom_range(1, 3);
        repeat (k) body.push_back(eol_char());
      end else begin
        body.push_back(QPD_EQ);
      end
    end
    // Leave an escape open at the end now and then
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      body.push_back(QPD_EQ);
    end else if (kind == 1) begin
      body.push_back(QPD_EQ);
      body.push_back(hex_char($urandom_range(0, 15), 1'b0));
    end
    foreach (body[i]) drive_item(body[i], i == body.size() - 1);
  endtask

  initial begin
    int load_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bodies: extremes, escapes, soft breaks and every ending
    drive_item(8'h00, 1'b0);
    drive_item(8'hFF, 1'b0);
    drive_item(QPD_EQ, 1'b0);
    drive_item(8'h34, 1'b0);
    drive_item(8'h31, 1'b0);
    // soft break followed directly by another escape with a lowercase digit
    drive_item(QPD_EQ, 1'b0);
    drive_item(QPD_CR, 1'b0);
    drive_item(QPD_LF, 1'b0);
    drive_item(QPD_EQ, 1'b0);
    drive_item(8'h34, 1'b0);
    drive_item(8'h61, 1'b0);
    // second escape character CR is taken as a digit
    drive_item(QPD_EQ, 1'b0);
    drive_item(8'h34, 1'b0);
    drive_item(QPD_CR, 1'b0);
    // top-half characters go through the digit path
    drive_item(QPD_EQ, 1'b0);
    drive_item(8'h80, 1'b0);
    drive_item(8'hFF, 1'b0);
    drive_item(8'h41, 1'b1);
    // open escapes at the end of a body
    drive_item(QPD_EQ, 1'b1);
    drive_item(QPD_EQ, 1'b0);
    drive_item(8'h37, 1'b1);
    // escape completed by the last byte
    drive_item(QPD_EQ, 1'b0);
    drive_item(8'h33, 1'b0);
    drive_item(8'h44, 1'b1);
    // end inside a soft break
    drive_item(QPD_EQ, 1'b0);
    drive_item(QPD_LF, 1'b1);
    drain_results();

    // Random bodies under each idling pattern
    for (int load = 0; load < 4; load++) begin
      case (load)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      load_end = items_sent + ITEMS_PER_LOAD;
      while (items_sent < load_end) run_body();
      drain_results();
    end

    // Let the pipeline settle, then judge
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.error_count == 0) begin
      $display("tb_quoted_printable_decoder_unit passed");
    end else begin
      $display("tb_quoted_printable_decoder_unit failed");
    end
    $finish;
  end

endmodule

>>> quoted_printable_decoder_unit.f
sv/qpd_pkg.sv
sv/qpd_decode.sv
sv/quoted_printable_decoder_unit.sv
dv/tb_quoted_printable_decoder_unit.sv
